// ===== hdl/tlptb_pkg.sv =====
package tlptb_pkg;

    // Directory geometry of a 32-bit, 4 KiB page, two-level scheme.
    localparam int DIR_SLOTS  = 1024;
    localparam int SLOT_W     = 10;
    localparam int PAGE_W     = 20;
    localparam int ADDR_W     = 32;
    localparam int OFFSET_W   = 12;

    // Present and writable flags in the low bits of every entry word.
    localparam logic [OFFSET_W-1:0] ENTRY_FLAGS = 12'h003;

    // Operation codes of an input beat.
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_MAP     = 1'b1;

    // Configuration register indexes.
    localparam logic REG_DIR_BASE  = 1'b0;
    localparam logic REG_POOL_BASE = 1'b1;

endpackage

// ===== hdl/tlptb_ram.sv =====
module tlptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/two_level_page_table_builder_unit.sv =====
// Two-level page table builder. Each map beat gives a physical and a virtual
// page number and yields one table entry write, preceded by a directory entry
// write when its directory slot has no table yet; that slot then takes the
// next table of the pool. If the pool is exhausted, the beat yields a pool
// error result instead. A restart beat forgets every slot, empties the pool
// and yields no result. The mirror of slot owners lives in a 1024-entry RAM
// and a reverse map (table to slot) in a MAX_TABLES-entry RAM; a slot counts
// as owned when its stored table index is below the number of tables taken
// and that table's owner is the slot. After reset the block sweeps both RAMs
// clear and accepts no beat meanwhile. A map beat passes from acceptance
// through the slot lookup and then the owner lookup and decision, each one
// RAM read, to the output register; a second result, if any, follows the
// first. The next beat is accepted in the cycle after the last result is
// loaded into the output register. Output stalls hold the block in its
// output states.
module two_level_page_table_builder_unit #(
    parameter int MAX_TABLES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [tlptb_pkg::PAGE_W-1:0] i_phys_page,
    input  logic [tlptb_pkg::PAGE_W-1:0] i_virt_page,
    input  logic                        i_region_end,
    // Output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_write_valid,
    output logic [tlptb_pkg::ADDR_W-1:0] o_write_addr,
    output logic [tlptb_pkg::ADDR_W-1:0] o_write_data,
    output logic                        o_pool_error,
    output logic                        o_region_done,
    output logic                        o_last,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import tlptb_pkg::*;

    localparam int TIDX_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int CNT_W  = $clog2(MAX_TABLES + 1);
    localparam int CLR_W  = SLOT_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK1,
        S_LOOK2,
        S_OUT_A,
        S_OUT_B
    } t_state;

    t_state               r_state;
    logic [SLOT_W-1:0]    r_clr;
    logic [CNT_W-1:0]     r_used;
    logic [PAGE_W-1:0]    r_dir_base;
    logic [PAGE_W-1:0]    r_pool_base;

    // Beat being worked on.
    logic [PAGE_W-1:0]    r_phys;
    logic [SLOT_W-1:0]    r_slot;
    logic [SLOT_W-1:0]    r_offs;
    logic                 r_rend;
    logic [TIDX_W-1:0]    r_tidx;
    logic                 r_new;
    logic                 r_err;

    // RAM ports.
    logic                 slot_we;
    logic [SLOT_W-1:0]    slot_waddr;
    logic [TIDX_W-1:0]    slot_wdata;
    logic [SLOT_W-1:0]    slot_raddr;
    logic [TIDX_W-1:0]    slot_rdata;
    logic                 own_we;
    logic [TIDX_W-1:0]    own_waddr;
    logic [SLOT_W-1:0]    own_wdata;
    logic [SLOT_W-1:0]    own_rdata;

    logic                 in_accept;
    logic                 out_free;
    logic                 out_load;
    logic                 hit;
    logic                 full;
    logic                 alloc;
    logic                 cfg_write;
    logic [PAGE_W-1:0]    tpage;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free  = !o_out_valid || !i_out_stall;
    assign out_load  = out_free && ((r_state == S_OUT_A) || (r_state == S_OUT_B));

    // The slot is owned only if its index is live and the table points back.
    assign hit   = (CNT_W'(r_tidx) < r_used) && (own_rdata == r_slot);
    assign full  = (r_used == CNT_W'(MAX_TABLES));
    assign alloc = (r_state == S_LOOK2) && !hit && !full;
    assign tpage = r_pool_base + PAGE_W'(r_tidx);

    // Mirror RAM: swept clear after reset, written on allocation.
    always_comb begin
        if (r_state == S_CLEAR) begin
            slot_we    = 1'b1;
            slot_waddr = r_clr;
            slot_wdata = '0;
            own_we     = (CLR_W'(r_clr) < CLR_W'(MAX_TABLES));
            own_waddr  = TIDX_W'(r_clr);
            own_wdata  = '0;
        end else begin
            slot_we    = alloc;
            slot_waddr = r_slot;
            slot_wdata = TIDX_W'(r_used);
            own_we     = alloc;
            own_waddr  = TIDX_W'(r_used);
            own_wdata  = r_slot;
        end
        slot_raddr = (r_state == S_IDLE) ? i_virt_page[PAGE_W-1:PAGE_W-SLOT_W] : r_slot;
    end

    tlptb_ram #(
        .WIDTH (TIDX_W),
        .DEPTH (DIR_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // The stored index straight from the slot RAM drives the owner lookup.
    tlptb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_TABLES)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (slot_rdata),
        .o_rdata (own_rdata)
    );

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_base  <= '0;
            r_pool_base <= PAGE_W'(1);
        end else if (cfg_write) begin
            if (paddr[2] == REG_DIR_BASE) begin
                r_dir_base <= pwdata[PAGE_W-1:0];
            end else begin
                r_pool_base <= pwdata[PAGE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_POOL_BASE) begin
            prdata = {{(32-PAGE_W){1'b0}}, r_pool_base};
        end else begin
            prdata = {{(32-PAGE_W){1'b0}}, r_dir_base};
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SLOT_W'(1);
                    if (r_clr == SLOT_W'(DIR_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_phys <= i_phys_page;
                        r_slot <= i_virt_page[PAGE_W-1:PAGE_W-SLOT_W];
                        r_offs <= i_virt_page[SLOT_W-1:0];
                        r_rend <= i_region_end;
                        if (i_op == OP_RESTART) begin
                            r_used <= '0;
                        end else begin
                            r_state <= S_LOOK1;
                        end
                    end
                end
                S_LOOK1: begin
                    // Stored index is kept for the owner check next cycle.
                    r_tidx  <= slot_rdata;
                    r_state <= S_LOOK2;
                end
                S_LOOK2: begin
                    r_new <= !hit && !full;
                    r_err <= !hit && full;
                    if (alloc) begin
                        r_tidx <= TIDX_W'(r_used);
                        r_used <= r_used + CNT_W'(1);
                    end
                    r_state <= S_OUT_A;
                end
                S_OUT_A: begin
                    if (out_free) begin
                        if (r_err) begin
                            o_write_valid <= 1'b0;
                            o_write_addr  <= '0;
                            o_write_data  <= '0;
                            o_pool_error  <= 1'b1;
                            o_region_done <= r_rend;
                            o_last        <= 1'b1;
                            r_state       <= S_IDLE;
                        end else if (r_new) begin
                            o_write_valid <= 1'b1;
                            o_write_addr  <= {r_dir_base, r_slot, 2'b00};
                            o_write_data  <= {tpage, ENTRY_FLAGS};
                            o_pool_error  <= 1'b0;
                            o_region_done <= 1'b0;
                            o_last        <= 1'b0;
                            r_state       <= S_OUT_B;
                        end else begin
                            o_write_valid <= 1'b1;
                            o_write_addr  <= {tpage, r_offs, 2'b00};
                            o_write_data  <= {r_phys, ENTRY_FLAGS};
                            o_pool_error  <= 1'b0;
                            o_region_done <= r_rend;
                            o_last        <= 1'b1;
                            r_state       <= S_IDLE;
                        end
                    end
                end
                S_OUT_B: begin
                    if (out_free) begin
                        o_write_valid <= 1'b1;
                        o_write_addr  <= {tpage, r_offs, 2'b00};
                        o_write_data  <= {r_phys, ENTRY_FLAGS};
                        o_pool_error  <= 1'b0;
                        o_region_done <= r_rend;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
